[sv/mme_pkg.sv]
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and constants of the matrix multiply engine: command codes,
// default sizes, the beat that walks the cell chain and the store write bus.
// ----------------------------------------------------------------------------
package mme_pkg;

    // default matrix geometry and element width
    localparam int ROWS_DEFAULT          = 4;
    localparam int INNER_DEFAULT         = 4;
    localparam int COLS_DEFAULT          = 4;
    localparam int ELEMENT_WIDTH_DEFAULT = 16;

    // field widths fixed by the stream format
    localparam int CMD_W       = 2;
    localparam int FIELD_IDX_W = 2;
    localparam int VALUE_W     = 16;
    localparam int ACC_W       = 32;

    // internal row / column counters cover up to eight rows or columns
    localparam int IDX_W = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_LEFT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_RIGHT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE    = 2'd2;

    // one product element in flight along the chain
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [ACC_W-1:0] psum;
    } token_t;

    // store write request to one cell
    typedef struct packed {
        logic                   left_we;
        logic                   right_we;
        logic [FIELD_IDX_W-1:0] addr;
        logic [VALUE_W-1:0]     value;
    } wr_t;

endpackage

[sv/matrix_multiply_engine_unit.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_engine_unit
// Integer matrix multiplier built as a chain of INNER multiply-accumulate
// cells; cell n holds left column n and right row n.
// ----------------------------------------------------------------------------
// output: after a compute beat the first product element passes the sequencer
//   state, the INNER cells and the output register, then one element a cycle
//   while the output is taken
// input: loads one a cycle while no compute run is in flight; a compute beat
//   blocks input until the sequencer walk is done and the chain has drained
// reset: both matrix stores clear to zero, chain and output register empty
// ----------------------------------------------------------------------------
module matrix_multiply_engine_unit
    import mme_pkg::*;
#(
    parameter int ROWS          = ROWS_DEFAULT,
    parameter int INNER         = INNER_DEFAULT,
    parameter int COLS          = COLS_DEFAULT,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // row_index[1:0], col_index[3:2], element_value[19:4]
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // out_row[1:0], out_col[3:2], product_value[35:4]
    output logic        m_axis_tlast   // last_of_run
);

    logic [CMD_W-1:0]       command;
    logic [FIELD_IDX_W-1:0] row_index;
    logic [FIELD_IDX_W-1:0] col_index;
    logic [VALUE_W-1:0]     element_value;
    logic                   in_beat;
    logic                   left_ok;
    logic                   right_ok;
    logic                   en;
    logic                   seq_running;
    logic                   chain_busy;
    logic                   start;
    wr_t                    wr [INNER];
    token_t                 tok [INNER+1];
    token_t                 tail;

    logic                   m_valid_reg;
    logic [FIELD_IDX_W-1:0] m_row_reg;
    logic [FIELD_IDX_W-1:0] m_col_reg;
    logic [ACC_W-1:0]       m_prod_reg;
    logic                   m_last_reg;

    // input beat fields
    assign command       = s_axis_tuser;
    assign row_index     = s_axis_tdata[1:0];
    assign col_index     = s_axis_tdata[3:2];
    assign element_value = s_axis_tdata[19:4];

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign left_ok  = (int'(row_index) < ROWS) && (int'(col_index) < INNER);
    assign right_ok = (int'(row_index) < INNER) && (int'(col_index) < COLS);
    assign start    = in_beat && (command == CMD_COMPUTE);

    // chain advances unless the output register holds an untaken beat
    assign en = !m_valid_reg || m_axis_tready;

    // accept only with the chain drained so loads never race a compute run
    always_comb
    begin
        chain_busy = 1'b0;
        for (int n = 1; n <= INNER; n++)
        begin
            chain_busy = chain_busy || tok[n].valid;
        end
    end

    assign s_axis_tready = !seq_running && !chain_busy;

    // route a load to the cell that owns the element
    always_comb
    begin
        for (int n = 0; n < INNER; n++)
        begin
            wr[n].left_we  = in_beat && (command == CMD_LOAD_LEFT) && left_ok
                             && (int'(col_index) == n);
            wr[n].right_we = in_beat && (command == CMD_LOAD_RIGHT) && right_ok
                             && (int'(row_index) == n);
            wr[n].addr     = (command == CMD_LOAD_LEFT) ? row_index : col_index;
            wr[n].value    = element_value;
        end
    end

    mme_seq #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .en      (en),
        .running (seq_running),
        .tok     (tok[0])
    );

    // multiply-accumulate chain
    for (genvar g = 0; g < INNER; g++)
    begin : g_cell
        mme_cell #(
            .ROWS          (ROWS),
            .COLS          (COLS),
            .ELEMENT_WIDTH (ELEMENT_WIDTH)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .wr      (wr[g]),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    assign tail = tok[INNER];

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_row_reg  <= tail.row[FIELD_IDX_W-1:0];
            m_col_reg  <= tail.col[FIELD_IDX_W-1:0];
            m_prod_reg <= tail.psum;
            m_last_reg <= tail.last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, m_prod_reg, m_col_reg, m_row_reg};
    assign m_axis_tlast  = m_last_reg;

    // a compute beat starts the sequencer
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> seq_running)
        else $error("compute beat did not start the sequencer");

    // no input accepted while elements are in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_running || chain_busy) |-> !s_axis_tready)
        else $error("input accepted during a compute run");

    // the marked element is the bottom-right one
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            ((m_row_reg == FIELD_IDX_W'(ROWS - 1)) && (m_col_reg == FIELD_IDX_W'(COLS - 1))))
        else $error("last_of_run on a wrong element");

    // a stalled output holds the chain
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(tail.valid) && $stable(tail.psum))
        else $error("chain moved during an output stall");

endmodule

[sv/mme_cell.sv]
// ----------------------------------------------------------------------------
// mme_cell
// One multiply-accumulate cell. Holds column n of the left matrix and row n
// of the right matrix, adds its product term to the passing partial sum and
// hands the beat to the next cell.
// ----------------------------------------------------------------------------
module mme_cell
    import mme_pkg::*;
#(
    parameter int ROWS          = ROWS_DEFAULT,
    parameter int COLS          = COLS_DEFAULT,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  wr_t    wr,
    input  token_t tok_in,
    output token_t tok_out
);

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

    logic signed [ELEMENT_WIDTH-1:0]   left_col_reg  [ROWS];
    logic signed [ELEMENT_WIDTH-1:0]   right_row_reg [COLS];
    logic signed [ELEMENT_WIDTH-1:0]   left_op;
    logic signed [ELEMENT_WIDTH-1:0]   right_op;
    logic signed [2*ELEMENT_WIDTH-1:0] prod;
    token_t                            tok_reg;
    token_t                            tok_next;

    // local store writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROWS; k++)
            begin
                left_col_reg[k] <= '0;
            end
            for (int k = 0; k < COLS; k++)
            begin
                right_row_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < ROWS; k++)
            begin
                if (wr.left_we && (int'(wr.addr) == k))
                begin
                    left_col_reg[k] <= wr.value[ELEMENT_WIDTH-1:0];
                end
            end
            for (int k = 0; k < COLS; k++)
            begin
                if (wr.right_we && (int'(wr.addr) == k))
                begin
                    right_row_reg[k] <= wr.value[ELEMENT_WIDTH-1:0];
                end
            end
        end
    end

    // product term for the passing element, wrapped into the partial sum
    always_comb
    begin
        left_op        = left_col_reg[tok_in.row[ROW_W-1:0]];
        right_op       = right_row_reg[tok_in.col[COL_W-1:0]];
        prod           = left_op * right_op;
        tok_next       = tok_in;
        tok_next.psum  = tok_in.psum + ACC_W'(prod);
    end

    // hand off to the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (en)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[sv/mme_seq.sv]
// ----------------------------------------------------------------------------
// mme_seq
// Compute sequencer. Walks the product matrix in row-major order and feeds
// one element a cycle, while the chain is not held, into the head of the cell chain.
// ----------------------------------------------------------------------------
module mme_seq
    import mme_pkg::*;
#(
    parameter int ROWS = ROWS_DEFAULT,
    parameter int COLS = COLS_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  logic   en,
    output logic   running,
    output token_t tok
);

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [ROW_W-1:0] i_reg;
    logic [ROW_W-1:0] i_next;
    logic [COL_W-1:0] j_reg;
    logic [COL_W-1:0] j_next;
    logic             last;

    assign last = (i_reg == ROW_LAST) && (j_reg == COL_LAST);

    // next state and counter advance
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    j_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (en)
                begin
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (j_reg == COL_LAST)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    // element entering the chain
    always_comb
    begin
        running   = (state_reg == ST_RUN);
        tok.valid = running;
        tok.last  = last;
        tok.row   = IDX_W'(i_reg);
        tok.col   = IDX_W'(j_reg);
        tok.psum  = '0;
    end

endmodule

[tb/tb_matrix_multiply_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply_engine_unit
// Streams element loads, compute commands and unused commands into the
// matrix multiply engine, with random gaps on both sides, and checks every
// product beat field by field against a scoreboard model of both matrices.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_engine_unit;
    import mme_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES   = 1000000;
    localparam int TAIL_BEATS     = 60;
    localparam int HOLD_AT_BEAT   = 60;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_BEATS   = 450;

    typedef struct {
        logic [CMD_W-1:0]       cmd;
        logic [FIELD_IDX_W-1:0] row;
        logic [FIELD_IDX_W-1:0] col;
        logic [VALUE_W-1:0]     value;
        bit                     drain_first;
    } stim_beat_t;

    typedef struct {
        logic [FIELD_IDX_W-1:0] row;
        logic [FIELD_IDX_W-1:0] col;
        logic [ACC_W-1:0]       value;
        logic                   last;
    } product_elem_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // row_index[1:0], col_index[3:2], element_value[19:4]
    logic [1:0]  s_axis_tuser = '0;  // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;       // out_row[1:0], out_col[3:2], product_value[35:4]
    logic        m_axis_tlast;

    // scoreboard copy of both matrix stores
    logic signed [VALUE_W-1:0] left_elems  [ROWS_DEFAULT][INNER_DEFAULT];
    logic signed [VALUE_W-1:0] right_elems [INNER_DEFAULT][COLS_DEFAULT];

    stim_beat_t    pending_beats[$];
    product_elem_t expected_products[$];

    int beats_offered = 0;
    int beats_taken = 0;
    int compute_runs = 0;
    int ignored_beats = 0;
    int products_checked = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int take_gap = 0;
    int long_hold = 0;
    bit long_hold_done = 1'b0;

    matrix_multiply_engine_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // reset held from time zero, released away from any edge
    initial
    begin
        repeat (9) @(posedge clk);
        #2 rst_n = 1'b1;
    end

    // update the matrix model for one accepted beat, queue products on compute
    task automatic apply_matrix_beat(input logic [CMD_W-1:0] cmd,
                                     input logic [FIELD_IDX_W-1:0] row,
                                     input logic [FIELD_IDX_W-1:0] col,
                                     input logic [VALUE_W-1:0] value);
        product_elem_t elem;
        int acc;
        if (cmd == CMD_LOAD_LEFT)
        begin
            if (row < ROWS_DEFAULT && col < INNER_DEFAULT)
                left_elems[row][col] = value;
        end
        else if (cmd == CMD_LOAD_RIGHT)
        begin
            if (row < INNER_DEFAULT && col < COLS_DEFAULT)
                right_elems[row][col] = value;
        end
        else if (cmd == CMD_COMPUTE)
        begin
            compute_runs++;
            for (int i = 0; i < ROWS_DEFAULT; i++)
            begin
                for (int j = 0; j < COLS_DEFAULT; j++)
                begin
                    // int arithmetic wraps modulo 2^32 like the hardware sum
                    acc = 0;
                    for (int n = 0; n < INNER_DEFAULT; n++)
                        acc += int'(left_elems[i][n]) * int'(right_elems[n][j]);
                    elem.row   = FIELD_IDX_W'(i);
                    elem.col   = FIELD_IDX_W'(j);
                    elem.value = acc;
                    elem.last  = (i == ROWS_DEFAULT - 1) && (j == COLS_DEFAULT - 1);
                    expected_products.push_back(elem);
                end
            end
        end
        else
            ignored_beats++;
    endtask

    task automatic add_beat(input logic [CMD_W-1:0] cmd, input int row, input int col,
                            input logic [VALUE_W-1:0] value, input bit drain_first);
        stim_beat_t beat;
        beat.cmd         = cmd;
        beat.row         = FIELD_IDX_W'(row);
        beat.col         = FIELD_IDX_W'(col);
        beat.value       = value;
        beat.drain_first = drain_first;
        pending_beats.push_back(beat);
    endtask

    // element values weighted toward the extremes
    function automatic logic [VALUE_W-1:0] pick_element();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return VALUE_W'($urandom_range(0, 15));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // scoreboard: input beats feed the model, output beats are checked
    always @(posedge clk)
    begin
        product_elem_t want;
        logic [FIELD_IDX_W-1:0] got_row;
        logic [FIELD_IDX_W-1:0] got_col;
        logic [ACC_W-1:0] got_value;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_row   = m_axis_tdata[1:0];
                got_col   = m_axis_tdata[3:2];
                got_value = m_axis_tdata[35:4];
                if (expected_products.size() == 0)
                begin
                    $display("%0t: product beat with nothing expected: row %0d col %0d value %0d",
                             $time, got_row, got_col, $signed(got_value));
                    mismatches++;
                end
                else
                begin
                    want = expected_products.pop_front();
                    products_checked++;
                    if (got_row !== want.row)
                    begin
                        $display("%0t: out_row expected %0d actual %0d", $time, want.row, got_row);
                        mismatches++;
                    end
                    if (got_col !== want.col)
                    begin
                        $display("%0t: out_col expected %0d actual %0d", $time, want.col, got_col);
                        mismatches++;
                    end
                    if (got_value !== want.value)
                    begin
                        $display("%0t: product_value (%0d,%0d) expected %0d actual %0d", $time,
                                 want.row, want.col, $signed(want.value), $signed(got_value));
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $display("%0t: last_of_run (%0d,%0d) expected %0b actual %0b", $time,
                                 want.row, want.col, want.last, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_matrix_beat(s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[3:2],
                                  s_axis_tdata[19:4]);
                beats_taken++;
            end
        end
    end

    // driver: next beat after the current one is taken, with random idle bursts
    always @(negedge clk)
    begin
        stim_beat_t beat;
        logic offer;
        if (rst_n)
        begin
            offer = s_axis_tvalid && (beats_taken != beats_offered);
            if (!offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_beats.size() > 0 &&
                         !(pending_beats[0].drain_first && expected_products.size() != 0))
                begin
                    if (pending_beats.size() >= TAIL_BEATS && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(0, 13);
                    else
                    begin
                        beat = pending_beats.pop_front();
                        s_axis_tdata <= {4'b0000, beat.value, beat.col, beat.row};
                        s_axis_tuser <= beat.cmd;
                        beats_offered++;
                        offer = 1'b1;
                    end
                end
            end
            s_axis_tvalid <= offer;
        end
    end

    // receiver: random stalls plus one long hold-off to back the engine up
    always @(negedge clk)
    begin
        logic ready;
        if (rst_n)
        begin
            ready = 1'b0;
            if (long_hold > 0)
                long_hold--;
            else if (!long_hold_done && beats_taken >= HOLD_AT_BEAT)
            begin
                long_hold_done = 1'b1;
                long_hold = HOLD_CYCLES - 1;
            end
            else if (take_gap > 0)
                take_gap--;
            else if (pending_beats.size() >= TAIL_BEATS && $urandom_range(0, 5) == 0)
                take_gap = $urandom_range(0, 13);
            else
                ready = 1'b1;
            m_axis_tready <= ready;
        end
    end

    // run limit
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped at the %0d cycle limit", LIMIT_CYCLES);
        $display("tb_matrix_multiply_engine_unit: done, errors");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        int counted;
        int drain_at;
        bit drain_next;
        int pick;
        for (int i = 0; i < ROWS_DEFAULT; i++)
            for (int k = 0; k < INNER_DEFAULT; k++)
                left_elems[i][k] = '0;
        for (int k = 0; k < INNER_DEFAULT; k++)
            for (int j = 0; j < COLS_DEFAULT; j++)
                right_elems[k][j] = '0;

        // product of the cleared stores is all zeros
        add_beat(CMD_COMPUTE, 3, 3, 16'hffff, 1'b0);
        // unused command must not touch the stores
        add_beat(CMD_UNUSED, 1, 1, 16'h7fff, 1'b0);
        // most negative row times most negative column wraps to zero
        for (int k = 0; k < 4; k++)
            add_beat(CMD_LOAD_LEFT, 0, k, 16'h8000, 1'b0);
        for (int k = 0; k < 4; k++)
            add_beat(CMD_LOAD_RIGHT, k, 0, 16'h8000, 1'b0);
        add_beat(CMD_LOAD_LEFT, 3, 3, 16'h7fff, 1'b0);
        add_beat(CMD_LOAD_RIGHT, 3, 3, 16'h7fff, 1'b0);
        add_beat(CMD_LOAD_LEFT, 2, 1, 16'hffff, 1'b0);
        add_beat(CMD_LOAD_RIGHT, 1, 2, 16'h8000, 1'b0);
        add_beat(CMD_COMPUTE, 0, 0, 16'h0000, 1'b0);
        // alternating bit patterns, then overwrite of a loaded element
        add_beat(CMD_LOAD_LEFT, 1, 2, 16'h5555, 1'b0);
        add_beat(CMD_LOAD_RIGHT, 2, 1, 16'haaaa, 1'b0);
        add_beat(CMD_LOAD_LEFT, 0, 0, 16'h0001, 1'b0);
        add_beat(CMD_COMPUTE, 2, 1, 16'h1234, 1'b0);
        add_beat(CMD_COMPUTE, 1, 2, 16'hedcb, 1'b0);

        // random mix: single loads, full reloads, computes and unused commands
        counted = 0;
        drain_at = 150;
        while (counted < RANDOM_BEATS)
        begin
            drain_next = (counted >= drain_at);
            if (drain_next)
                drain_at += 150;
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                for (int i = 0; i < ROWS_DEFAULT; i++)
                    for (int k = 0; k < INNER_DEFAULT; k++)
                        add_beat(CMD_LOAD_LEFT, i, k, pick_element(),
                                 drain_next && i == 0 && k == 0);
                for (int k = 0; k < INNER_DEFAULT; k++)
                    for (int j = 0; j < COLS_DEFAULT; j++)
                        add_beat(CMD_LOAD_RIGHT, k, j, pick_element(), 1'b0);
                add_beat(CMD_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 3),
                         VALUE_W'($urandom), 1'b0);
                counted += ROWS_DEFAULT * INNER_DEFAULT + INNER_DEFAULT * COLS_DEFAULT + 1;
            end
            else if (pick < 14)
            begin
                add_beat(CMD_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 3),
                         VALUE_W'($urandom), drain_next);
                counted++;
            end
            else if (pick < 19)
            begin
                add_beat(CMD_UNUSED, $urandom_range(0, 3), $urandom_range(0, 3),
                         VALUE_W'($urandom), drain_next);
                counted++;
            end
            else
            begin
                add_beat($urandom_range(0, 1) ? CMD_LOAD_RIGHT : CMD_LOAD_LEFT,
                         $urandom_range(0, 3), $urandom_range(0, 3), pick_element(),
                         drain_next);
                counted++;
            end
        end
        add_beat(CMD_COMPUTE, 0, 0, 16'h0000, 1'b0);

        // wait for every beat to be taken and every product to arrive
        @(posedge rst_n);
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_products.size() != 0)
            @(posedge clk);
        repeat (INNER_DEFAULT + 24) @(posedge clk);

        $display("covered %0d input beats: %0d compute runs, %0d unused commands",
                 beats_taken, compute_runs, ignored_beats);
        $display("checked %0d product elements, %0d mismatches", products_checked, mismatches);
        if (mismatches == 0)
            $display("tb_matrix_multiply_engine_unit: done, clean");
        else
            $display("tb_matrix_multiply_engine_unit: done, errors");
        $finish;
    end

endmodule
